// ----- rtl/pesd_pkg.sv -----
// Package for the particle Euler step block: payload structs, register indexes
// and pipeline dimensions. Depends on nothing; used by every file in rtl.
package pesd_pkg;

	localparam int NUM_STAGES = 19;
	localparam int DIV_FIRST  = 2;
	localparam int DIV_STEPS  = 16;
	localparam int DIV_LAST   = DIV_FIRST + DIV_STEPS - 1;

	localparam logic [12:0] DT_MAX  = 13'd6554;
	localparam logic [16:0] ONE_Q16 = 17'd65536;

	localparam logic [2:0] REG_FRAME_TIME = 3'd0;
	localparam logic [2:0] REG_DRAG_RATE  = 3'd1;
	localparam logic [2:0] REG_GRAVITY_X  = 3'd2;
	localparam logic [2:0] REG_GRAVITY_Y  = 3'd3;
	localparam logic [2:0] REG_GRAVITY_Z  = 3'd4;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [31:0] vel_z;
		logic [30:0]        age_in;
		logic [30:0]        lifetime;
		logic [30:0]        size_start;
		logic [30:0]        size_end;
	} particle_t;

	typedef struct packed {
		logic signed [31:0] new_pos_x;
		logic signed [31:0] new_pos_y;
		logic signed [31:0] new_pos_z;
		logic signed [31:0] new_vel_x;
		logic signed [31:0] new_vel_y;
		logic signed [31:0] new_vel_z;
		logic [30:0]        age_out;
		logic [30:0]        current_size;
		logic [16:0]        life_progress;
		logic               expired;
	} result_t;

endpackage

// ----- rtl/pesd_div.sv -----
// Pipelined restoring divider giving one quotient bit per stage.
// Depends on pesd_pkg; stage enables come from the top level's ready chain.
module pesd_div (
	input  logic                            clk,
	input  logic [pesd_pkg::DIV_STEPS-1:0] ld,
	input  logic [30:0]                     num,
	input  logic [30:0]                     den,
	output logic [pesd_pkg::DIV_STEPS-1:0] quo
);
	import pesd_pkg::*;

	logic [30:0]          rem_s [DIV_STEPS];
	logic [30:0]          den_s [DIV_STEPS];
	logic [DIV_STEPS-1:0] quo_s [DIV_STEPS];
	logic [31:0]          trial [DIV_STEPS];
	logic [31:0]          diff  [DIV_STEPS];
	logic                 take  [DIV_STEPS];

	// The numerant is below the divisor whenever the quotient is used, so
	// the remainder always fits 31 bits.
	always_comb begin
		for (int j = 0; j < DIV_STEPS; j++) begin
			if (j == 0)
				trial[j] = {num, 1'b0};
			else
				trial[j] = {rem_s[j-1], 1'b0};
			if (j == 0)
				diff[j] = trial[j] - {1'b0, den};
			else
				diff[j] = trial[j] - {1'b0, den_s[j-1]};
			take[j] = (j == 0) ? (trial[j] >= {1'b0, den}) : (trial[j] >= {1'b0, den_s[j-1]});
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < DIV_STEPS; j++) begin
			if (ld[j]) begin
				rem_s[j] <= take[j] ? diff[j][30:0] : trial[j][30:0];
				den_s[j] <= (j == 0) ? den : den_s[j-1];
				if (j == 0)
					quo_s[j] <= {{(DIV_STEPS-1){1'b0}}, take[j]};
				else
					quo_s[j] <= {quo_s[j-1][DIV_STEPS-2:0], take[j]};
			end
		end
	end

	assign quo = quo_s[DIV_STEPS-1];

endmodule

// ----- rtl/particle_euler_step_with_drag.sv -----
// Top level of the particle Euler step with gravity and exponential drag.
// Depends on pesd_pkg and pesd_div.
//
// Usage: one particle enters on the particle channel (particle_valid, particle,
// particle_stall) and one result leaves on the result channel (result_valid,
// result, result_stall) for each. A transaction completes at a rising edge with
// valid high and stall low. The block runs as a 19-stage pipeline: one particle
// can enter every cycle while particle_stall is low. The drag factor is rebuilt
// in the pipeline for each particle from the registers; the life progress comes
// from a 16-stage divider giving one quotient bit per stage, which sets the
// depth. Empty stages are filled while the output is stalled, so input is still
// taken until all 19 stages hold a particle; only then is particle_stall raised.
// The user writes configuration (cfg_wen, cfg_index, cfg_data) only while the
// pipeline is empty; the block does not enforce it. Reset clears all valid bits
// and restores register defaults: frame time 1092, no drag, gravity -9.8 on y.
module particle_euler_step_with_drag (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                particle_valid,
	output logic                particle_stall,
	input  pesd_pkg::particle_t particle,
	output logic                result_valid,
	input  logic                result_stall,
	output pesd_pkg::result_t   result,
	input  logic                cfg_wen,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_data
);
	import pesd_pkg::*;

	typedef struct packed {
		logic [2:0][31:0] pos;
		logic [2:0][31:0] vel;
		logic [30:0]      age;
		logic [30:0]      life;
		logic [30:0]      s0;
		logic [30:0]      s1;
		logic [12:0]      dt;
	} car_t;

	function automatic logic [31:0] sat32(input logic signed [32:0] x);
		if (x[32] != x[31])
			return x[32] ? 32'h8000_0000 : 32'h7fff_ffff;
		return x[31:0];
	endfunction

	logic [12:0]        frame_time_q;
	logic [20:0]        drag_rate_q;
	logic [2:0][31:0]   grav_q;

	logic [NUM_STAGES:1] v_s;
	logic [NUM_STAGES:1] rdy;
	car_t                car_s [1:NUM_STAGES];
	car_t                car_in [2:NUM_STAGES];

	logic [33:0]               dragdt_s1;
	logic signed [2:0][45:0]   gdt_s1;
	logic [14:0]               y_s2, y_s3;
	logic [29:0]               yy_s2;
	logic [13:0]               t2_s3;
	logic [28:0]               t2y_s3;
	logic [27:0]               t3y_s4;
	logic [26:0]               t3r_s4;
	logic [16:0]               part_s4, part_s5;
	logic [23:0]               t4r_s5;
	logic [16:0]               e_s6, e_s7, e_s8, e_s9;
	logic signed [2:0][45:0]   vdt_s11;
	logic [16:0]               prog_s18, prog_s19;
	logic signed [49:0]        sprod_s18;
	logic [30:0]               size_s19;
	logic                      exp_s19;

	logic [12:0]               dt_c;
	logic [31:0]               age_sum;
	logic [2:0][31:0]          vel1_c;
	logic [2:0][31:0]          vel2_c;
	logic [2:0][31:0]          pos1_c;
	logic [2:0][31:0]          pos_in, vel_in;
	logic [13:0]               t2_c;
	logic [12:0]               t3_c;
	logic [11:0]               t4_c;
	logic [33:0]               sq7_c, sq8_c, sq9_c;
	logic signed [49:0]        vprod_c [3];
	logic [DIV_STEPS-1:0]      quo;
	logic [16:0]               prog_c;
	logic signed [31:0]        sdiff_c;
	logic signed [34:0]        size_c;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_time_q <= 13'd1092;
			drag_rate_q  <= '0;
			grav_q[0]    <= '0;
			grav_q[1]    <= 32'hfff6_3333;
			grav_q[2]    <= '0;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_FRAME_TIME: frame_time_q <= cfg_data[12:0];
				REG_DRAG_RATE:  drag_rate_q  <= cfg_data[20:0];
				REG_GRAVITY_X:  grav_q[0]    <= cfg_data;
				REG_GRAVITY_Y:  grav_q[1]    <= cfg_data;
				REG_GRAVITY_Z:  grav_q[2]    <= cfg_data;
				default: ;
			endcase
		end
	end

	// A stage may load when it is empty or when the stage after it moves on.
	always_comb begin
		rdy[NUM_STAGES] = !v_s[NUM_STAGES] || !result_stall;
		for (int k = NUM_STAGES - 1; k >= 1; k--)
			rdy[k] = !v_s[k] || rdy[k+1];
	end

	assign particle_stall = !rdy[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			if (rdy[1])
				v_s[1] <= particle_valid;
			for (int k = 2; k <= NUM_STAGES; k++)
				if (rdy[k])
					v_s[k] <= v_s[k-1];
		end
	end

	always_comb begin
		dt_c    = (frame_time_q > DT_MAX) ? DT_MAX : frame_time_q;
		age_sum = {1'b0, particle.age_in} + {19'd0, dt_c};
		pos_in  = {particle.pos_z, particle.pos_y, particle.pos_x};
		vel_in  = {particle.vel_z, particle.vel_y, particle.vel_x};
		t2_c    = yy_s2[29:16];
		t3_c    = t2y_s3[28:16];
		t4_c    = t3y_s4[27:16];
		sq7_c   = {17'd0, e_s6} * {17'd0, e_s6};
		sq8_c   = {17'd0, e_s7} * {17'd0, e_s7};
		sq9_c   = {17'd0, e_s8} * {17'd0, e_s8};
		for (int i = 0; i < 3; i++) begin
			vel1_c[i] = sat32($signed({car_s[1].vel[i][31], car_s[1].vel[i]})
				+ $signed(gdt_s1[i][45:16]));
			vprod_c[i] = $signed(car_s[9].vel[i]) * $signed({1'b0, e_s9});
			vel2_c[i]  = vprod_c[i][47:16];
			pos1_c[i] = sat32($signed({car_s[11].pos[i][31], car_s[11].pos[i]})
				+ $signed(vdt_s11[i][45:16]));
		end
		for (int k = 2; k <= NUM_STAGES; k++)
			car_in[k] = car_s[k-1];
		car_in[2].vel  = vel1_c;
		car_in[10].vel = vel2_c;
		car_in[12].pos = pos1_c;
		if (car_s[17].life == '0 || car_s[17].age >= car_s[17].life)
			prog_c = ONE_Q16;
		else
			prog_c = {1'b0, quo};
		sdiff_c = $signed({1'b0, car_s[17].s1}) - $signed({1'b0, car_s[17].s0});
		size_c  = $signed({4'd0, car_s[18].s0}) + $signed(sprod_s18[49:16]);
	end

	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			car_s[1].pos  <= pos_in;
			car_s[1].vel  <= vel_in;
			car_s[1].age  <= age_sum[31] ? 31'h7fff_ffff : age_sum[30:0];
			car_s[1].life <= particle.lifetime;
			car_s[1].s0   <= particle.size_start;
			car_s[1].s1   <= particle.size_end;
			car_s[1].dt   <= dt_c;
			dragdt_s1     <= {13'd0, drag_rate_q} * {21'd0, dt_c};
			for (int i = 0; i < 3; i++)
				gdt_s1[i] <= $signed(grav_q[i]) * $signed({1'b0, dt_c});
		end
		for (int k = 2; k <= NUM_STAGES; k++)
			if (rdy[k])
				car_s[k] <= car_in[k];

		// Damping factor: a fourth-order series of exp(-x/8), squared three times.
		if (rdy[2]) begin
			y_s2  <= dragdt_s1[33:19];
			yy_s2 <= {15'd0, dragdt_s1[33:19]} * {15'd0, dragdt_s1[33:19]};
		end
		if (rdy[3]) begin
			y_s3   <= y_s2;
			t2_s3  <= t2_c;
			t2y_s3 <= {15'd0, t2_c} * {14'd0, y_s2};
		end
		if (rdy[4]) begin
			t3y_s4  <= {15'd0, t3_c} * {13'd0, y_s3};
			// Multiplying by 10923 / 2^16 gives the exact floor of a division by six here.
			t3r_s4  <= {14'd0, t3_c} * 27'd10923;
			part_s4 <= ONE_Q16 - {2'd0, y_s3} + {4'd0, t2_s3[13:1]};
		end
		if (rdy[5]) begin
			t4r_s5  <= {12'd0, t4_c} * 24'd2731;
			part_s5 <= part_s4 - {6'd0, t3r_s4[26:16]};
		end
		if (rdy[6])
			e_s6 <= part_s5 + {9'd0, t4r_s5[23:16]};
		if (rdy[7])
			e_s7 <= sq7_c[32:16];
		if (rdy[8])
			e_s8 <= sq8_c[32:16];
		if (rdy[9])
			e_s9 <= sq9_c[32:16];
		if (rdy[11])
			for (int i = 0; i < 3; i++)
				vdt_s11[i] <= $signed(car_s[10].vel[i]) * $signed({1'b0, car_s[10].dt});
		if (rdy[18]) begin
			prog_s18  <= prog_c;
			sprod_s18 <= sdiff_c * $signed({1'b0, prog_c});
		end
		if (rdy[19]) begin
			prog_s19 <= prog_s18;
			size_s19 <= size_c[30:0];
			exp_s19  <= car_s[18].age >= car_s[18].life;
		end
	end

	pesd_div u_div (
		.clk (clk),
		.ld  (rdy[DIV_LAST:DIV_FIRST]),
		.num (car_s[1].age),
		.den (car_s[1].life),
		.quo (quo)
	);

	assign result_valid         = v_s[NUM_STAGES];
	assign result.new_pos_x     = car_s[NUM_STAGES].pos[0];
	assign result.new_pos_y     = car_s[NUM_STAGES].pos[1];
	assign result.new_pos_z     = car_s[NUM_STAGES].pos[2];
	assign result.new_vel_x     = car_s[NUM_STAGES].vel[0];
	assign result.new_vel_y     = car_s[NUM_STAGES].vel[1];
	assign result.new_vel_z     = car_s[NUM_STAGES].vel[2];
	assign result.age_out       = car_s[NUM_STAGES].age;
	assign result.current_size  = size_s19;
	assign result.life_progress = prog_s19;
	assign result.expired       = exp_s19;

endmodule

// ----- rtl/pesd_chk.sv -----
// Port-level checks on the particle Euler step block, attached by bind.
// Depends on pesd_pkg and the top level particle_euler_step_with_drag.
module pesd_chk (
	input logic                clk,
	input logic                arst_n,
	input logic                particle_stall,
	input logic                result_valid,
	input logic                result_stall,
	input pesd_pkg::result_t   result
);
	import pesd_pkg::*;

	// The pipeline is empty straight after reset.
	a_reset_empty: assert property (@(posedge clk) $rose(arst_n) |-> !result_valid)
		else $error("result valid straight after reset");

	// With the last stage empty every stage can move, so input is taken.
	a_empty_takes: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> !particle_stall)
		else $error("input stalled while output stage empty");

	// An unstalled output lets the whole pipeline advance.
	a_flow_through: assert property (@(posedge clk) disable iff (!arst_n)
		!result_stall |-> !particle_stall)
		else $error("input stalled while output flows");

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result transaction changed");

endmodule

bind particle_euler_step_with_drag pesd_chk u_pesd_chk (.*);

// ----- sim/testbench.sv -----
// Self-checking testbench for particle_euler_step_with_drag: drives particles with random
// gaps, predicts each Euler step with drag in 64-bit integer terms and checks every result.
// Depends on pesd_pkg and the block's RTL.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import pesd_pkg::*;

	localparam int LATENCY = 19;
	localparam int WATCHDOG_LIMIT = 20000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        particle_valid = 1'b0;
	logic        particle_stall;
	particle_t   particle = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	result_t     result;
	logic        cfg_wen = 1'b0;
	logic [2:0]  cfg_index = REG_FRAME_TIME;
	logic [31:0] cfg_data = '0;

	// Shadow copy of the configuration registers.
	logic [12:0]        frame_time_q;
	logic [20:0]        drag_rate_q;
	logic signed [31:0] grav_q [3];

	result_t     expected_steps [$];
	int          error_count = 0;
	int          idle_cycles = 0;
	int          stall_left = 0;
	bit          stall_enable = 1'b1;

	particle_euler_step_with_drag dut (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic longint floor_shr(longint x, int n);
		return x >>> n;
	endfunction

	function automatic longint sat_s32(longint x);
		if (x > 64'sd2147483647)
			return 64'sd2147483647;
		if (x < -64'sd2147483648)
			return -64'sd2147483648;
		return x;
	endfunction

	function automatic longint unsigned drag_factor(longint unsigned drag, longint unsigned dt);
		longint unsigned y, t2, t3, t4, e;
		y  = (drag * dt) >> 19;
		t2 = (y * y) >> 16;
		t3 = (t2 * y) >> 16;
		t4 = (t3 * y) >> 16;
		e  = 65536 - y + t2 / 2 - t3 / 6 + t4 / 24;
		for (int i = 0; i < 3; i++)
			e = (e * e) >> 16;
		return e;
	endfunction

	function automatic result_t euler_step(particle_t p);
		result_t         r;
		longint unsigned dt, e, age, life, prog;
		longint          pos [3];
		longint          vel [3];
		longint          v1, v2, s0, s1;
		dt = (frame_time_q > DT_MAX) ? DT_MAX : frame_time_q;
		e = drag_factor(drag_rate_q, dt);
		pos[0] = p.pos_x; pos[1] = p.pos_y; pos[2] = p.pos_z;
		vel[0] = p.vel_x; vel[1] = p.vel_y; vel[2] = p.vel_z;
		for (int k = 0; k < 3; k++) begin
			v1 = sat_s32(vel[k] + floor_shr(longint'(grav_q[k]) * longint'(dt), 16));
			v2 = floor_shr(v1 * longint'(e), 16);
			vel[k] = v2;
			pos[k] = sat_s32(pos[k] + floor_shr(v2 * longint'(dt), 16));
		end
		age = longint'(p.age_in) + dt;
		if (age > 64'h7FFFFFFF)
			age = 64'h7FFFFFFF;
		life = p.lifetime;
		if (life == 0 || age >= life)
			prog = 65536;
		else
			prog = (age << 16) / life;
		s0 = p.size_start;
		s1 = p.size_end;
		r.new_pos_x = pos[0][31:0]; r.new_pos_y = pos[1][31:0]; r.new_pos_z = pos[2][31:0];
		r.new_vel_x = vel[0][31:0]; r.new_vel_y = vel[1][31:0]; r.new_vel_z = vel[2][31:0];
		r.age_out = age[30:0];
		r.current_size = 31'(s0 + floor_shr((s1 - s0) * longint'(prog), 16));
		r.life_progress = prog[16:0];
		r.expired = (age >= life);
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		error_count++;
		$display("MISMATCH %s: got %0d expected %0d", what, got, want);
	endtask

	function automatic int random_gap();
		if ($urandom_range(0, 9) < 6)
			return 0;
		if ($urandom_range(0, 9) < 8)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Result side: random stall and a check of each transaction.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			idle_cycles <= 0;
			if (expected_steps.size() == 0) begin
				report_mismatch("unexpected result", 0, 0);
			end else begin
				want = expected_steps.pop_front();
				if (result.new_pos_x !== want.new_pos_x)
					report_mismatch("new_pos_x", result.new_pos_x, want.new_pos_x);
				if (result.new_pos_y !== want.new_pos_y)
					report_mismatch("new_pos_y", result.new_pos_y, want.new_pos_y);
				if (result.new_pos_z !== want.new_pos_z)
					report_mismatch("new_pos_z", result.new_pos_z, want.new_pos_z);
				if (result.new_vel_x !== want.new_vel_x)
					report_mismatch("new_vel_x", result.new_vel_x, want.new_vel_x);
				if (result.new_vel_y !== want.new_vel_y)
					report_mismatch("new_vel_y", result.new_vel_y, want.new_vel_y);
				if (result.new_vel_z !== want.new_vel_z)
					report_mismatch("new_vel_z", result.new_vel_z, want.new_vel_z);
				if (result.age_out !== want.age_out)
					report_mismatch("age_out", result.age_out, want.age_out);
				if (result.current_size !== want.current_size)
					report_mismatch("current_size", result.current_size, want.current_size);
				if (result.life_progress !== want.life_progress)
					report_mismatch("life_progress", result.life_progress, want.life_progress);
				if (result.expired !== want.expired)
					report_mismatch("expired", result.expired, want.expired);
			end
		end else if (arst_n && !(particle_valid && !particle_stall)) begin
			idle_cycles <= idle_cycles + 1;
		end else begin
			idle_cycles <= 0;
		end
		// Mostly short stalls, now and then a long one.
		if (stall_enable && stall_left > 0) begin
			result_stall <= 1'b1;
			stall_left   <= stall_left - 1;
		end else if (stall_enable && $urandom_range(0, 9) < 3) begin
			result_stall <= 1'b1;
			stall_left   <= ($urandom_range(0, 49) == 0) ? int'($urandom_range(10, 40)) : 0;
		end else begin
			result_stall <= 1'b0;
			stall_left   <= 0;
		end
	end

	always @(posedge clk) begin
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [31:0] value);
		cfg_wen   <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_wen <= 1'b0;
		case (idx)
			REG_FRAME_TIME: frame_time_q = value[12:0];
			REG_DRAG_RATE:  drag_rate_q  = value[20:0];
			REG_GRAVITY_X:  grav_q[0]    = value;
			REG_GRAVITY_Y:  grav_q[1]    = value;
			REG_GRAVITY_Z:  grav_q[2]    = value;
			default: ;
		endcase
	endtask

	task automatic send_particle(particle_t p, bit gaps);
		int gap;
		gap = gaps ? random_gap() : 0;
		if (gap > 0) begin
			particle_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		particle_valid <= 1'b1;
		particle       <= p;
		@(posedge clk);
		while (particle_stall)
			@(posedge clk);
		expected_steps.insert(expected_steps.size(), euler_step(p));
	endtask

	task automatic drain();
		particle_valid <= 1'b0;
		while (expected_steps.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	function automatic logic [31:0] edge_word();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0;
			3: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	function automatic particle_t random_particle();
		particle_t p;
		p.pos_x = edge_word(); p.pos_y = edge_word(); p.pos_z = edge_word();
		p.vel_x = edge_word(); p.vel_y = edge_word(); p.vel_z = edge_word();
		if ($urandom_range(0, 3) == 0) begin
			p.age_in = 31'(edge_word()); p.lifetime = 31'(edge_word());
		end else begin
			// Realistic ages and lifetimes, so that progress falls between 0 and 1.
			p.lifetime = 31'($urandom_range(0, 10 << 16));
			p.age_in = 31'($urandom_range(0, 12 << 16));
		end
		p.size_start = 31'($urandom);
		p.size_end = ($urandom_range(0, 3) == 0) ? 31'(edge_word()) : 31'($urandom);
		return p;
	endfunction

	task automatic test_directed();
		particle_t p;
		p = '0;
		send_particle(p, 0);
		p.lifetime = 31'd100 << 16;
		p.size_end = 31'h7FFF_FFFF;
		send_particle(p, 0);
		p.pos_x = 32'h7FFF_FFFF; p.vel_x = 32'h7FFF_FFFF;
		p.pos_y = 32'h8000_0000; p.vel_y = 32'h8000_0000;
		p.pos_z = 32'h8000_0000; p.vel_z = 32'h7FFF_FFFF;
		p.age_in = 31'h7FFF_FFFF; p.lifetime = 31'h7FFF_FFFF;
		p.size_start = 31'h7FFF_FFFF; p.size_end = '0;
		send_particle(p, 0);
		p.age_in = 31'h7FFF_FF00; p.lifetime = 31'h7FFF_FFFF;
		send_particle(p, 0);
		p.age_in = 31'd1 << 16; p.lifetime = 31'd1 << 16;
		send_particle(p, 0);
		p.lifetime = (31'd1 << 16) + 31'd1092;
		send_particle(p, 0);
		p.lifetime = 31'd3;
		send_particle(p, 0);
		drain();
		// Frame time above the limit, extreme drag and gravity.
		write_reg(REG_FRAME_TIME, 32'h1FFF);
		write_reg(REG_DRAG_RATE, 32'h1F_FFFF);
		write_reg(REG_GRAVITY_X, 32'h7FFF_FFFF);
		write_reg(REG_GRAVITY_Y, 32'h8000_0000);
		write_reg(REG_GRAVITY_Z, 32'hFFFF_FFFF);
		for (int i = 0; i < 8; i++)
			send_particle(random_particle(), 0);
		drain();
		write_reg(REG_FRAME_TIME, 32'd0);
		write_reg(REG_DRAG_RATE, 32'd1 << 20);
		for (int i = 0; i < 6; i++)
			send_particle(random_particle(), 0);
		drain();
	endtask

	task automatic test_random_phase(int count);
		write_reg(REG_FRAME_TIME, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191) :
			$urandom_range(0, DT_MAX));
		write_reg(REG_DRAG_RATE, $urandom_range(0, 3) == 0 ? 32'h1F_FFFF :
			$urandom_range(0, 1 << 20));
		write_reg(REG_GRAVITY_X, ($urandom_range(0, 1) == 0) ? edge_word() :
			$urandom_range(0, 1 << 21) - (1 << 20));
		write_reg(REG_GRAVITY_Y, edge_word());
		write_reg(REG_GRAVITY_Z, $urandom);
		for (int i = 0; i < count; i++) begin
			send_particle(random_particle(), 1);
			// Now and then hold off until the pipeline has fully drained.
			if ($urandom_range(0, 59) == 0) begin
				particle_valid <= 1'b0;
				while (expected_steps.size() != 0)
					@(posedge clk);
			end
		end
		drain();
	endtask

	task automatic test_back_to_back();
		// No gaps and no output stall: full-rate streaming.
		stall_enable = 1'b0;
		for (int i = 0; i < 60; i++)
			send_particle(random_particle(), 0);
		drain();
		stall_enable = 1'b1;
	endtask

	initial begin
		frame_time_q = 13'd1092;
		drag_rate_q  = '0;
		grav_q[0] = 0;
		grav_q[1] = -32'sd642253;
		grav_q[2] = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		for (int ph = 0; ph < 6; ph++)
			test_random_phase(70);
		test_back_to_back();
		if (error_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
